FILE: rtl/trial_division_prime_generator_top_macros.svh
// Assertion macros shared by the RTL files.
// Checks are compiled only in simulation; synthesis sees empty bodies.
`ifndef TRIAL_DIVISION_PRIME_GENERATOR_TOP_MACROS_SVH
`define TRIAL_DIVISION_PRIME_GENERATOR_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Clocked check, masked while reset is asserted
`define TDPG_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("tdpg: check failed");

// Clocked check that also holds through reset
`define TDPG_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("tdpg: check failed");

`else

`define TDPG_ASSERT(label, clk, rst_n, prop)
`define TDPG_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

FILE: rtl/tdpg_pkg.sv
package tdpg_pkg;

    // Fixed field widths of the request and result words
    localparam int START_W = 16;
    localparam int COUNT_W = 7;
    localparam int VALUE_OUT_W = 32;
    localparam int INDEX_W = 6;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TEST,
        ST_CHECK,
        ST_DIV,
        ST_EMIT,
        ST_NEXT,
        ST_OVF
    } state_t;

    // Status returned by the remainder unit
    typedef struct packed {
        logic done;   // one-cycle pulse, remainder ready
        logic zero;   // remainder is zero (valid with done)
    } rem_stat_t;

endpackage

FILE: rtl/tdpg_rem.sv
`include "trial_division_prime_generator_top_macros.svh"

// Bit-serial remainder unit: one dividend bit per cycle, MSB first,
// restoring step against a narrow divisor.
module tdpg_rem #(
    parameter int VALUE_WIDTH = 32,
    localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start_i,
    input  logic [VALUE_WIDTH-1:0] dividend_i,
    input  logic [DIV_W-1:0]       divisor_i,
    output tdpg_pkg::rem_stat_t    stat_o
);

    localparam int CNT_W = $clog2(VALUE_WIDTH);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [VALUE_WIDTH-1:0] shift_reg, shift_next;
    logic [DIV_W-1:0]       rem_reg, rem_next;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;

    // One restoring step
    assign trial = {rem_reg, shift_reg[VALUE_WIDTH-1]};
    assign diff  = trial - {1'b0, divisor_i};

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;
        if (start_i) begin
            busy_next  = 1'b1;
            cnt_next   = CNT_W'(VALUE_WIDTH - 1);
            shift_next = dividend_i;
            rem_next   = '0;
        end else if (busy_reg) begin
            shift_next = {shift_reg[VALUE_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, divisor_i}) begin
                rem_next = diff[DIV_W-1:0];
            end else begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign stat_o.done = done_reg;
    assign stat_o.zero = (rem_reg == '0);

    // A new division never starts over one in flight
    `TDPG_ASSERT(a_rem_start_idle, aclk, aresetn, start_i |-> !busy_reg)
    // Final bit leads to the done pulse
    `TDPG_ASSERT(a_rem_done_follows, aclk, aresetn,
        (busy_reg && !start_i && cnt_reg == '0) |=> done_reg)
    // Done only once the unit has gone idle
    `TDPG_ASSERT(a_rem_done_idle, aclk, aresetn, done_reg |-> !busy_reg)

endmodule

FILE: rtl/trial_division_prime_generator_top.sv
// Channel  | Ports                                                          | Direction
// request  | s_valid s_ready s_start_value s_prime_count                    | in
// result   | m_valid m_ready m_prime_value m_prime_index m_last m_overflow  | out
//
// Each candidate is set up and then divided by each trial divisor in turn in the
// bit-serial remainder unit; a prime near n costs about sqrt(n) divisors.
// A request lasts as long as its search runs.
// Reset (aresetn low, synchronous) returns to idle with no result pending.
// The search stalls only when a result is ready and the output word is
// still held; the next request is taken as soon as the last result is loaded.
`include "trial_division_prime_generator_top_macros.svh"

module trial_division_prime_generator_top #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_RUN = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [tdpg_pkg::START_W-1:0]        s_start_value,
    input  logic [tdpg_pkg::COUNT_W-1:0]        s_prime_count,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [tdpg_pkg::VALUE_OUT_W-1:0]    m_prime_value,
    output logic [tdpg_pkg::INDEX_W-1:0]        m_prime_index,
    output logic                                m_last,
    output logic                                m_overflow
);

    localparam int DIV_W = (VALUE_WIDTH + 1) / 2 + 1;
    localparam int SQ_W = VALUE_WIDTH + 2;
    localparam int CW = tdpg_pkg::COUNT_W;
    localparam int SW = tdpg_pkg::START_W;
    localparam int OW = tdpg_pkg::VALUE_OUT_W;

    tdpg_pkg::state_t state_reg, state_next;

    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [DIV_W-1:0]       d_reg, d_next;
    logic [SQ_W-1:0]        sq_reg, sq_next;
    logic [CW-1:0]          want_reg, want_next;
    logic [CW-1:0]          found_reg, found_next;

    logic                           m_valid_reg, m_valid_next;
    logic [OW-1:0]                  val_reg, val_next;
    logic [tdpg_pkg::INDEX_W-1:0]   idx_reg, idx_next;
    logic                           last_reg, last_next;
    logic                           ovf_reg, ovf_next;

    logic                    rem_start;
    tdpg_pkg::rem_stat_t     rem_stat;

    logic [VALUE_WIDTH+SW-1:0] start_ext;
    logic                      start_above;
    logic [VALUE_WIDTH+OW-1:0] val_ext;
    logic [SQ_W-1:0]           n_ext;
    logic [CW-1:0]             found_inc;
    logic [CW-1:0]             want_sat;
    logic                      out_free;
    logic                      run_last;

    // Request decode: start beyond the range, saturated count
    assign start_ext   = {{VALUE_WIDTH{1'b0}}, s_start_value};
    assign start_above = |start_ext[VALUE_WIDTH+SW-1:VALUE_WIDTH];
    assign want_sat    = (s_prime_count > CW'(MAX_RUN)) ? CW'(MAX_RUN) : s_prime_count;

    assign val_ext   = {{OW{1'b0}}, n_reg};
    assign n_ext     = {2'b00, n_reg};
    assign found_inc = found_reg + CW'(1);
    assign run_last  = (found_inc == want_reg);
    assign out_free  = !m_valid_reg || m_ready;

    tdpg_rem #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_rem (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (rem_start),
        .dividend_i (n_reg),
        .divisor_i  (d_reg),
        .stat_o     (rem_stat)
    );

    // Search sequencer and output word load
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        d_next       = d_reg;
        sq_next      = sq_reg;
        want_next    = want_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_ready;
        val_next     = val_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        ovf_next     = ovf_reg;
        rem_start    = 1'b0;
        s_ready      = 1'b0;
        case (state_reg)
            tdpg_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    want_next  = want_sat;
                    found_next = '0;
                    n_next     = start_ext[VALUE_WIDTH-1:0];
                    if (want_sat == '0) begin
                        state_next = tdpg_pkg::ST_IDLE;
                    end else if (start_above) begin
                        state_next = tdpg_pkg::ST_OVF;
                    end else begin
                        state_next = tdpg_pkg::ST_TEST;
                    end
                end
            end
            tdpg_pkg::ST_TEST: begin
                d_next  = DIV_W'(2);
                sq_next = SQ_W'(4);
                if (n_reg < VALUE_WIDTH'(2)) begin
                    state_next = tdpg_pkg::ST_NEXT;
                end else begin
                    state_next = tdpg_pkg::ST_CHECK;
                end
            end
            tdpg_pkg::ST_CHECK: begin
                if (sq_reg > n_ext) begin
                    state_next = tdpg_pkg::ST_EMIT;
                end else begin
                    rem_start  = 1'b1;
                    state_next = tdpg_pkg::ST_DIV;
                end
            end
            tdpg_pkg::ST_DIV: begin
                if (rem_stat.done) begin
                    if (rem_stat.zero) begin
                        state_next = tdpg_pkg::ST_NEXT;
                    end else begin
                        // (d+1)^2 = d^2 + 2d + 1
                        d_next     = d_reg + DIV_W'(1);
                        sq_next    = sq_reg + SQ_W'({d_reg, 1'b1});
                        state_next = tdpg_pkg::ST_CHECK;
                    end
                end
            end
            tdpg_pkg::ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    val_next     = val_ext[OW-1:0];
                    idx_next     = found_reg[tdpg_pkg::INDEX_W-1:0];
                    last_next    = run_last;
                    ovf_next     = 1'b0;
                    found_next   = found_inc;
                    state_next   = run_last ? tdpg_pkg::ST_IDLE : tdpg_pkg::ST_NEXT;
                end
            end
            tdpg_pkg::ST_NEXT: begin
                if (&n_reg) begin
                    state_next = tdpg_pkg::ST_OVF;
                end else begin
                    n_next     = n_reg + VALUE_WIDTH'(1);
                    state_next = tdpg_pkg::ST_TEST;
                end
            end
            tdpg_pkg::ST_OVF: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    val_next     = '0;
                    idx_next     = found_reg[tdpg_pkg::INDEX_W-1:0];
                    last_next    = 1'b1;
                    ovf_next     = 1'b1;
                    state_next   = tdpg_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tdpg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= tdpg_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            want_reg    <= '0;
            found_reg   <= '0;
            n_reg       <= '0;
            d_reg       <= DIV_W'(2);
            sq_reg      <= SQ_W'(4);
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            want_reg    <= want_next;
            found_reg   <= found_next;
            n_reg       <= n_next;
            d_reg       <= d_next;
            sq_reg      <= sq_next;
        end
        val_reg  <= val_next;
        idx_reg  <= idx_next;
        last_reg <= last_next;
        ovf_reg  <= ovf_next;
    end

    assign m_valid       = m_valid_reg;
    assign m_prime_value = val_reg;
    assign m_prime_index = idx_reg;
    assign m_last        = last_reg;
    assign m_overflow    = ovf_reg;

    // Reset leaves the block idle with no word pending
    `TDPG_ASSERT_ALWAYS(a_reset_idle, aclk,
        !aresetn |=> (state_reg == tdpg_pkg::ST_IDLE && !m_valid_reg))
    // Run never counts past its request
    `TDPG_ASSERT(a_found_bound, aclk, aresetn, found_reg <= want_reg)
    // A prime is only reported once the divisor square passed the candidate
    `TDPG_ASSERT(a_emit_tested, aclk, aresetn,
        (state_reg == tdpg_pkg::ST_EMIT) |-> (sq_reg > n_ext && n_reg >= VALUE_WIDTH'(2)))
    // Trial divisors start at two
    `TDPG_ASSERT(a_div_divisor, aclk, aresetn,
        (state_reg == tdpg_pkg::ST_DIV) |-> (d_reg >= DIV_W'(2)))
    // Overflow word always closes the run
    `TDPG_ASSERT(a_ovf_last, aclk, aresetn, (m_valid_reg && ovf_reg) |-> last_reg)

endmodule
